[rtl/htsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsa_pkg
// Shared sizes, action codes and encoder helpers for the handle table slot
// allocator.
// ----------------------------------------------------------------------------
package htsa_pkg;

  // Table geometry
  localparam int SLOTS       = 64;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GRP         = 8;
  localparam int GRP_BIT_W   = 3;
  localparam int GROUPS      = (SLOTS + GRP - 1) / GRP;
  localparam int GRP_IDX_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int OCC_N       = GROUPS * GRP;
  localparam int OCC_W       = $clog2(OCC_N);
  localparam int FREE_W      = GRP_IDX_W + GRP_BIT_W;

  // Field widths
  localparam int ACT_W       = 2;
  localparam int IDX_W       = 8;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 9;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  typedef logic [GROUPS-1:0] grp_vec_t;
  typedef logic [GRP-1:0]    grp_bits_t;

  // Lowest group that still has a free slot
  function automatic logic [GRP_IDX_W-1:0] first_open_grp(input grp_vec_t full);
    logic [GRP_IDX_W-1:0] sel;
    sel = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (!full[i]) begin
        sel = GRP_IDX_W'(i);
      end
    end
    return sel;
  endfunction

  // Lowest clear bit inside one group
  function automatic logic [GRP_BIT_W-1:0] first_clear_bit(input grp_bits_t bits);
    logic [GRP_BIT_W-1:0] sel;
    sel = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        sel = GRP_BIT_W'(i);
      end
    end
    return sel;
  endfunction

endpackage

[rtl/handle_table_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_table_slot_allocator
// First-fit slot allocator: an occupancy bitmap in flops with per-group full
// flags, and a handle store in a one-port-write, one-port-read memory.
// Pipeline: a memory read stage, then an output register.
// Throughput: one item per cycle while the output is not stalled, bounded by the single store access per item.
// Reset: all slots free, count zero, pipeline empty; store contents are left
//   as they are, since a slot is read only while occupied.
// ----------------------------------------------------------------------------
module handle_table_slot_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [htsa_pkg::ACT_W-1:0]   action,
  input  logic [htsa_pkg::IDX_W-1:0]   slot_index,
  input  logic [htsa_pkg::DATA_W-1:0]  entry_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [htsa_pkg::IDX_W-1:0]   slot_used,
  output logic [htsa_pkg::DATA_W-1:0]  handle_out,
  output logic [htsa_pkg::CNT_W-1:0]   occupied_total
);
  import htsa_pkg::*;

  // Occupancy state
  logic [OCC_N-1:0]   occ;
  grp_vec_t           grp_full;
  logic [CNT_W-1:0]   count;

  // Handle store
  logic [DATA_W-1:0]  mem [SLOTS];
  logic [DATA_W-1:0]  rd_data;

  // Stage 1 (memory read in flight)
  logic               s1_valid;
  logic               s1_ok;
  logic               s1_rd;
  logic [IDX_W-1:0]   s1_slot;
  logic [CNT_W-1:0]   s1_total;

  logic               s1_adv;
  logic               accept;
  logic [GRP_IDX_W-1:0] grp_sel;
  grp_bits_t          grp_bits;
  logic [GRP_BIT_W-1:0] bit_sel;
  logic [FREE_W-1:0]  free_slot;
  logic               full;
  logic               in_range;
  logic               hit;
  logic               do_put;
  logic               do_get;
  logic               do_remove;
  logic               put_grp_full;
  logic [CNT_W-1:0]   count_next;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // Two-level first-fit search: pick the group, then the bit inside it
  assign full      = &grp_full;
  assign grp_sel   = first_open_grp(grp_full);
  assign grp_bits  = occ[GRP*grp_sel +: GRP];
  assign bit_sel   = first_clear_bit(grp_bits);
  assign free_slot = {grp_sel, bit_sel};

  assign in_range  = {1'b0, slot_index} < CNT_W'(SLOTS);
  assign hit       = in_range && occ[slot_index[OCC_W-1:0]];

  always_comb begin
    do_put    = 1'b0;
    do_get    = 1'b0;
    do_remove = 1'b0;
    unique case (action)
      ACT_PUT:    do_put    = !full;
      ACT_GET:    do_get    = hit;
      ACT_REMOVE: do_remove = hit;
      default: begin
      end
    endcase
  end

  assign put_grp_full = &(grp_bits | (grp_bits_t'(1) << bit_sel));

  always_comb begin
    count_next = count;
    if (do_put) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Control and occupancy state
  always_ff @(posedge clk) begin
    if (rst) begin
      // padding bits past the table stay marked occupied
      for (int i = 0; i < OCC_N; i++) begin
        occ[i] <= (i >= SLOTS);
      end
      grp_full  <= '0;
      count     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        if (do_put) begin
          occ[free_slot[OCC_W-1:0]] <= 1'b1;
          grp_full[grp_sel]         <= put_grp_full;
        end else if (do_remove) begin
          occ[slot_index[OCC_W-1:0]]            <= 1'b0;
          grp_full[slot_index[OCC_W-1:GRP_BIT_W]] <= 1'b0;
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok    <= do_put || do_get || do_remove;
      s1_rd    <= do_get || do_remove;
      s1_slot  <= do_put ? IDX_W'(free_slot) : '0;
      s1_total <= count_next;
    end
    if (s1_adv) begin
      ok             <= s1_ok;
      slot_used      <= s1_slot;
      handle_out     <= s1_rd ? rd_data : '0;
      occupied_total <= s1_total;
    end
  end

  // Handle store: write on put, read on get or remove; rd_data holds while
  // stage 1 waits since reads happen only on accept
  always_ff @(posedge clk) begin
    if (accept && do_put) begin
      mem[free_slot[SLOT_W-1:0]] <= entry_value;
    end
    if (accept && (do_get || do_remove)) begin
      rd_data <= mem[slot_index[SLOT_W-1:0]];
    end
  end

endmodule

[tb/sv/htsa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsa_checker
// Watches both channels of the handle table slot allocator. Each accepted
// item updates a local copy of the slot table and queues the result it
// should produce. Each accepted result is compared field by field with the
// oldest queued one. Counts go back to the testbench top.
// ----------------------------------------------------------------------------
module htsa_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [htsa_pkg::ACT_W-1:0]  action,
  input  logic [htsa_pkg::IDX_W-1:0]  slot_index,
  input  logic [htsa_pkg::DATA_W-1:0] entry_value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        ok,
  input  logic [htsa_pkg::IDX_W-1:0]  slot_used,
  input  logic [htsa_pkg::DATA_W-1:0] handle_out,
  input  logic [htsa_pkg::CNT_W-1:0]  occupied_total,
  output int                          fail_count,
  output int                          pending,
  output int                          checked_count,
  output int                          full_rejects
);
  import htsa_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] handle;
    logic [CNT_W-1:0]  total;
  } table_result_t;

  logic              slot_busy [SLOTS];
  logic [DATA_W-1:0] slot_handle [SLOTS];
  logic [CNT_W-1:0]  busy_count;
  table_result_t     result_q [$];

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Apply one operation to the local table and return the result it gives.
  function automatic table_result_t apply_op(input logic [ACT_W-1:0]  act,
                                             input logic [IDX_W-1:0]  idx,
                                             input logic [DATA_W-1:0] val);
    table_result_t r;
    bit            placed;
    r = '0;
    placed = 1'b0;
    case (act)
      ACT_PUT: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (!placed && !slot_busy[k]) begin
            placed = 1'b1;
            slot_busy[k] = 1'b1;
            slot_handle[k] = val;
            busy_count = busy_count + 1'b1;
            r.ok = 1'b1;
            r.slot = IDX_W'(k);
          end
        end
      end
      ACT_GET: begin
        if (idx < SLOTS && slot_busy[idx[SLOT_W-1:0]]) begin
          r.ok = 1'b1;
          r.handle = slot_handle[idx[SLOT_W-1:0]];
        end
      end
      ACT_REMOVE: begin
        if (idx < SLOTS && slot_busy[idx[SLOT_W-1:0]]) begin
          r.ok = 1'b1;
          r.handle = slot_handle[idx[SLOT_W-1:0]];
          slot_handle[idx[SLOT_W-1:0]] = '0;
          slot_busy[idx[SLOT_W-1:0]] = 1'b0;
          busy_count = busy_count - 1'b1;
        end
      end
      default: ;
    endcase
    r.total = busy_count;
    return r;
  endfunction

  always @(posedge clk) begin : track
    table_result_t want;
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_busy[k] = 1'b0;
      end
      busy_count = '0;
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        want = apply_op(action, slot_index, entry_value);
        result_q.push_back(want);
        if (action == ACT_PUT && !want.ok) full_rejects++;
      end
      if (out_valid && !out_stall) begin
        checked_count++;
        if (result_q.size() == 0) begin
          report_mismatch("result arrived with no item waiting for it");
        end else begin
          want = result_q.pop_front();
          if (ok !== want.ok)
            report_mismatch($sformatf("ok %0b, want %0b", ok, want.ok));
          if (slot_used !== want.slot)
            report_mismatch($sformatf("slot_used %0d, want %0d", slot_used, want.slot));
          if (handle_out !== want.handle)
            report_mismatch($sformatf("handle_out %h, want %h", handle_out, want.handle));
          if (occupied_total !== want.total)
            report_mismatch($sformatf("occupied_total %0d, want %0d",
                                      occupied_total, want.total));
        end
      end
    end
    pending = result_q.size();
  end

endmodule

[tb/sv/tb_handle_table_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_table_slot_allocator
// Drives put, get, remove and unused-code items into the slot allocator
// under several sender-idle and receiver-stall mixes, including one long
// output hold-off, and leaves prediction and comparison to htsa_checker.
// ----------------------------------------------------------------------------
module tb_handle_table_slot_allocator;
  import htsa_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {BATCH_FILL, BATCH_DRAIN, BATCH_MIXED, BATCH_NOISE} batch_kind_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [ACT_W-1:0]  action;
  logic [IDX_W-1:0]  slot_index;
  logic [DATA_W-1:0] entry_value;
  logic              out_valid;
  logic              out_stall;
  logic              ok;
  logic [IDX_W-1:0]  slot_used;
  logic [DATA_W-1:0] handle_out;
  logic [CNT_W-1:0]  occupied_total;

  int fail_count;
  int pending;
  int checked_count;
  int full_rejects;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;
  int put_count = 0;
  int get_count = 0;
  int remove_count = 0;
  int unused_count = 0;

  handle_table_slot_allocator dut (.*);
  htsa_checker u_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, or one long hold-off when asked.
  initial begin
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("handle_table_slot_allocator test failed");
    $finish;
  end

  // Offer one item after random idle cycles; hold it until taken.
  task automatic send_op(input logic [ACT_W-1:0]  act,
                         input logic [IDX_W-1:0]  idx,
                         input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    slot_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (in_stall);
    case (act)
      ACT_PUT:    put_count++;
      ACT_GET:    get_count++;
      ACT_REMOVE: remove_count++;
      default:    unused_count++;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(99) < 88) return IDX_W'($urandom_range(SLOTS - 1));
    return IDX_W'($urandom_range(255, SLOTS));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_batch(input batch_kind_t kind, input int n);
    int               roll;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      idx = pick_index();
      case (kind)
        BATCH_FILL:  act = (roll < 85) ? ACT_PUT : (roll < 93) ? ACT_GET : ACT_REMOVE;
        BATCH_DRAIN: act = (roll < 75) ? ACT_REMOVE : (roll < 90) ? ACT_GET : ACT_PUT;
        BATCH_MIXED: act = (roll < 40) ? ACT_PUT : (roll < 70) ? ACT_GET : ACT_REMOVE;
        default: begin
          act = (roll < 50) ? ACT_UNUSED : (roll < 75) ? ACT_GET : ACT_REMOVE;
          idx = IDX_W'($urandom_range(255));
        end
      endcase
      send_op(act, idx, pick_value());
    end
  endtask

  // Walk every slot in order plus the first index past the table.
  task automatic sweep(input logic [ACT_W-1:0] act);
    for (int i = 0; i <= SLOTS; i++) begin
      send_op(act, IDX_W'(i), pick_value());
    end
  endtask

  task automatic run_round();
    run_batch(BATCH_FILL, 90);
    sweep(ACT_GET);
    run_batch(BATCH_MIXED, 60);
    run_batch(BATCH_FILL, 40);
    run_batch(BATCH_DRAIN, 80);
    sweep(ACT_REMOVE);
    run_batch(BATCH_NOISE, 16);
    run_batch(BATCH_MIXED, 60);
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    idle_mix = '{0, 59, 0, 27};
    stall_mix = '{0, 0, 59, 27};
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_PUT;
    slot_index <= '0;
    entry_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table, bounds, unused code
    send_op(ACT_GET, 8'd0, 32'h1111_1111);
    send_op(ACT_REMOVE, 8'd0, 32'h2222_2222);
    send_op(ACT_GET, 8'd255, '1);
    send_op(ACT_REMOVE, IDX_W'(SLOTS), '1);
    send_op(ACT_UNUSED, 8'hFF, '1);
    // fill low slots with edge values
    send_op(ACT_PUT, 8'hFF, '1);
    send_op(ACT_PUT, 8'd0, '0);
    send_op(ACT_PUT, 8'd7, 32'hA5A5_5A5A);
    send_op(ACT_GET, 8'd0, '0);
    send_op(ACT_GET, 8'd1, '1);
    send_op(ACT_GET, 8'd2, '0);
    send_op(ACT_GET, IDX_W'(SLOTS - 1), '0);
    // remove leaves a hole that the next put reclaims
    send_op(ACT_REMOVE, 8'd1, '0);
    send_op(ACT_GET, 8'd1, '0);
    send_op(ACT_REMOVE, 8'd1, '0);
    send_op(ACT_PUT, 8'd40, 32'h0123_4567);
    send_op(ACT_GET, 8'd1, '0);
    send_op(ACT_REMOVE, IDX_W'(SLOTS - 1), '0);
    send_op(ACT_UNUSED, 8'd0, 32'hDEAD_BEEF);
    send_op(ACT_REMOVE, 8'd0, '0);
    send_op(ACT_REMOVE, 8'd2, '1);
    send_op(ACT_REMOVE, 8'd1, '0);
    send_op(ACT_GET, 8'd3, '0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_mix[phase];
      stall_pct = stall_mix[phase];
      run_round();
      if (phase == 1) begin
        // back up the pipeline behind a held output, then let it all drain
        sender_idle_pct = 0;
        long_hold = 1'b1;
        run_batch(BATCH_MIXED, 40);
        drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d items (put %0d, get %0d, remove %0d, unused %0d); %0d results compared.",
             put_count + get_count + remove_count + unused_count,
             put_count, get_count, remove_count, unused_count, checked_count);
    $display("Table ran full %0d times; output held off %0d cycles once.",
             full_rejects, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("handle_table_slot_allocator test passed");
    end else begin
      if (pending != 0) $display("%0d results never arrived", pending);
      $display("handle_table_slot_allocator test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/htsa_pkg.sv
rtl/handle_table_slot_allocator.sv
tb/sv/htsa_checker.sv
tb/sv/tb_handle_table_slot_allocator.sv
